// File: sv/ggds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggds_pkg: shared types and constants for the gas grid diffusion sweep
// Opcodes, store geometry and the sequencer-to-divider request and response structs.
// ----------------------------------------------------------------------------
package ggds_pkg;
  localparam int CellBits  = 8;
  localparam int LaneBits  = 2;
  localparam int SlotBits  = CellBits + LaneBits;
  localparam int GasBits   = 28;
  localparam int FlowBits  = 32;
  localparam int BlkBits   = 4;
  localparam int SumBits   = 31;  // five 28-bit gas values

  localparam logic [GasBits-1:0] GasMax = {GasBits{1'b1}};

  localparam logic [2:0] OP_WR_GAS  = 3'd0;
  localparam logic [2:0] OP_WR_FLOW = 3'd1;
  localparam logic [2:0] OP_WR_BLK  = 3'd2;
  localparam logic [2:0] OP_SWEEP   = 3'd3;
  localparam logic [2:0] OP_RD_GAS  = 3'd4;
  localparam logic [2:0] OP_RD_FLOW = 3'd5;
  localparam logic [2:0] OP_RD_BLK  = 3'd6;

  // Divider command and status between sequencer and divider.
  typedef struct packed {
    logic             start;
    logic [SumBits-1:0] dividend;
    logic [2:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SumBits-1:0] quot;
    logic [2:0]       rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: sv/ggds_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggds_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ggds_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

// File: sv/ggds_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggds_div: restoring divider by a small divisor
// Produces one quotient bit per cycle; divisor is 1 to 5.
// ----------------------------------------------------------------------------
module ggds_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ggds_pkg::div_req_t req,
  output ggds_pkg::div_rsp_t     rsp
);
  import ggds_pkg::*;

  localparam int CntBits = $clog2(SumBits + 1);

  logic [SumBits-1:0] q_r, q_nxt;
  logic [3:0]         r_r, r_nxt;
  logic [2:0]         d_r, d_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [3:0]         trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r[2:0], q_r[SumBits-1]};
    if (req.start) begin
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = CntBits'(SumBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[SumBits-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[SumBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r[2:0];
endmodule
`default_nettype wire

// File: sv/gas_grid_diffusion_sweep_top.sv
`default_nettype none
// Gas grid diffusion sweep.
// A write passes S_HOUT and a read passes S_HRD then S_HOUT before out_valid is set.
// A sweep visits GRID_SIZE*(GRID_SIZE-2) cells; a visit lasts longer the more of its
// cells are open (one to five), set by the single store port (one access a cycle)
// and the divider run once per lane. One item at a time.
// Reset clears control state only; store contents are undefined until written.
// ----------------------------------------------------------------------------
// gas_grid_diffusion_sweep_top: cell store with in-place diffusion sweep
// Sequencer over gas, flow and blocked RAMs with a shared divider.
// ----------------------------------------------------------------------------
module gas_grid_diffusion_sweep_top #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_cell_index,
  input  wire logic [1:0]  in_lane,
  input  wire logic [27:0] in_gas_value,
  input  wire logic signed [31:0] in_flow_value,
  input  wire logic [3:0]  in_blocked_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_read_value,
  output logic             out_sweep_done
);
  import ggds_pkg::*;

  localparam int PosBits = $clog2(GRID_SIZE * GRID_SIZE + 1);
  localparam logic [PosBits-1:0] PosFirst = PosBits'(GRID_SIZE);
  localparam logic [PosBits-1:0] PosEnd   = PosBits'(GRID_SIZE * (GRID_SIZE - 1));
  localparam logic [CellBits-1:0] GridStep = CellBits'(GRID_SIZE);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HRD   = 4'd1;  // host read, wait data
  localparam logic [3:0] S_HOUT  = 4'd2;
  localparam logic [3:0] S_BLK   = 4'd3;  // read blocked bits
  localparam logic [3:0] S_GRD   = 4'd4;  // read gas for (lane, slot)
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_NWR   = 4'd6;  // read old neighbor gas, write avg
  localparam logic [3:0] S_NWR2  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;  // flow read-modify-write
  localparam logic [3:0] S_FWR   = 4'd9;
  localparam logic [3:0] S_CWR   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [CellBits-1:0] cell_r, cell_nxt;
  logic [LaneBits-1:0] lane_r, lane_nxt;
  logic [PosBits-1:0]  pos_r, pos_nxt;
  logic [BlkBits-1:0]  blk_r, blk_nxt;
  logic [2:0]          k_r, k_nxt;      // neighbor step 0..4, 4 = center
  logic [LaneBits-1:0] l_r, l_nxt;
  logic                ph_r, ph_nxt;    // phase: flow 0 neighbor, 1 center; reads 0 address, 1 data
  logic [SumBits-1:0]  sum_r, sum_nxt;
  logic [GasBits-1:0]  avg_r [4];
  logic [2:0]          rem_r [4];
  logic [FlowBits-1:0] d_r, d_nxt;
  logic [31:0]         rv_r, rv_nxt;
  logic                done_bit_r, done_bit_nxt;
  logic                ovalid_r, ovalid_nxt;

  logic                gwe, fwe, bwe;
  logic [SlotBits-1:0] gaddr, faddr;
  logic [CellBits-1:0] baddr;
  logic [GasBits-1:0]  gwdata, grdata;
  logic [FlowBits-1:0] fwdata, frdata;
  logic [BlkBits-1:0]  bwdata, brdata;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [CellBits-1:0] ctr, nb [4];
  logic [2:0]          open_cnt;
  logic [GasBits:0]    cval;
  logic                in_xfer;

  ggds_ram #(.Width(GasBits),  .Depth(1 << SlotBits)) u_gas (
    .clk, .we(gwe), .addr(gaddr), .wdata(gwdata), .rdata(grdata));
  ggds_ram #(.Width(FlowBits), .Depth(1 << SlotBits)) u_flow (
    .clk, .we(fwe), .addr(faddr), .wdata(fwdata), .rdata(frdata));
  ggds_ram #(.Width(BlkBits),  .Depth(1 << CellBits)) u_blk (
    .clk, .we(bwe), .addr(baddr), .wdata(bwdata), .rdata(brdata));

  ggds_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  assign in_stall = (state_r != S_IDLE) || ovalid_r;
  assign in_xfer  = in_valid && !in_stall;

  assign ctr   = pos_r[CellBits-1:0];
  assign nb[0] = ctr - GridStep;
  assign nb[1] = ctr - 1'b1;
  assign nb[2] = ctr + 1'b1;
  assign nb[3] = ctr + GridStep;
  assign open_cnt = 3'd5 - 3'($countones(blk_r));
  assign cval = {1'b0, avg_r[l_r]} + (GasBits+1)'(rem_r[l_r]);

  // cell picked by step k (k == 4 is the center)
  function automatic logic [CellBits-1:0] pick(input logic [2:0] k,
                                               input logic [CellBits-1:0] c,
                                               input logic [CellBits-1:0] n0,
                                               input logic [CellBits-1:0] n1,
                                               input logic [CellBits-1:0] n2,
                                               input logic [CellBits-1:0] n3);
    logic [CellBits-1:0] r;
    unique case (k)
      3'd0:    r = n0;
      3'd1:    r = n1;
      3'd2:    r = n2;
      3'd3:    r = n3;
      default: r = c;
    endcase
    return r;
  endfunction

  // next open neighbor step at or after k; 4 when none
  function automatic logic [2:0] next_open(input logic [2:0] k,
                                           input logic [BlkBits-1:0] b);
    logic [2:0] r;
    r = 3'd4;
    for (int i = 3; i >= 0; i--) begin
      if (3'(i) >= k && !b[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  logic [CellBits-1:0] cur_cell;
  assign cur_cell = pick(k_r, ctr, nb[0], nb[1], nb[2], nb[3]);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cell_nxt     = cell_r;
    lane_nxt     = lane_r;
    pos_nxt      = pos_r;
    blk_nxt      = blk_r;
    k_nxt        = k_r;
    l_nxt        = l_r;
    ph_nxt       = ph_r;
    sum_nxt      = sum_r;
    d_nxt        = d_r;
    rv_nxt       = rv_r;
    done_bit_nxt = done_bit_r;
    ovalid_nxt   = ovalid_r;
    gwe = 1'b0; fwe = 1'b0; bwe = 1'b0;
    gaddr  = {cur_cell, l_r};
    faddr  = {cur_cell, l_r};
    baddr  = ctr;
    gwdata = in_gas_value;
    fwdata = in_flow_value;
    bwdata = in_blocked_bits;
    dreq.start    = 1'b0;
    dreq.dividend = sum_r;
    dreq.divisor  = open_cnt;

    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        gaddr = {in_cell_index, in_lane};
        faddr = {in_cell_index, in_lane};
        baddr = in_cell_index;
        if (in_xfer) begin
          op_nxt       = in_opcode;
          cell_nxt     = in_cell_index;
          lane_nxt     = in_lane;
          rv_nxt       = '0;
          done_bit_nxt = 1'b0;
          priority case (in_opcode)
            OP_WR_GAS:  begin gwe = 1'b1; state_nxt = S_HOUT; end
            OP_WR_FLOW: begin fwe = 1'b1; state_nxt = S_HOUT; end
            OP_WR_BLK:  begin bwe = 1'b1; state_nxt = S_HOUT; end
            OP_SWEEP: begin
              pos_nxt   = PosFirst;
              state_nxt = (PosFirst < PosEnd) ? S_BLK : S_OUT;
              done_bit_nxt = 1'b1;
            end
            OP_RD_GAS, OP_RD_FLOW, OP_RD_BLK: state_nxt = S_HRD;
            default: state_nxt = S_HOUT;
          endcase
        end
      end
      S_HRD: begin
        priority case (op_r)
          OP_RD_GAS:  rv_nxt = {4'b0, grdata};
          OP_RD_FLOW: rv_nxt = frdata;
          default:    rv_nxt = {28'b0, brdata};
        endcase
        state_nxt = S_HOUT;
      end
      S_HOUT, S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          pos_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end
      S_BLK: begin
        // ph 0 presents ctr to the blocked RAM; ph 1 takes its registered data
        if (k_r == 3'd0 && !ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          blk_nxt = brdata;
          ph_nxt  = 1'b0;
          l_nxt   = '0;
          k_nxt   = 3'd4;
          sum_nxt = '0;
          ph_nxt  = 1'b0;
          state_nxt = S_GRD;
        end
      end
      S_GRD: begin
        // ph 0: issue address; ph 1: accumulate data
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt  = 1'b0;
          sum_nxt = sum_r + SumBits'(grdata);
          if (k_r == 3'd4) begin
            k_nxt = next_open(3'd0, blk_r);
          end else begin
            k_nxt = next_open(k_r + 3'd1, blk_r);
          end
          if (k_r != 3'd4 && next_open(k_r + 3'd1, blk_r) == 3'd4) begin
            state_nxt  = S_DIV;
            dreq.start = 1'b1;
            dreq.dividend = sum_r + SumBits'(grdata);
          end else if (k_r == 3'd4 && blk_r == 4'hF) begin
            state_nxt  = S_DIV;
            dreq.start = 1'b1;
            dreq.dividend = sum_r + SumBits'(grdata);
          end
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          if (l_r == 2'd3) begin
            k_nxt  = next_open(3'd0, blk_r);
            l_nxt  = '0;
            d_nxt  = '0;
            ph_nxt = 1'b0;
            state_nxt = (next_open(3'd0, blk_r) == 3'd4) ? S_CWR : S_NWR;
          end else begin
            l_nxt   = l_r + 1'b1;
            k_nxt   = 3'd4;
            sum_nxt = '0;
            ph_nxt  = 1'b0;
            state_nxt = S_GRD;
          end
        end
      end
      S_NWR: begin
        // read old neighbor gas for lane l
        state_nxt = S_NWR2;
      end
      S_NWR2: begin
        gwe    = 1'b1;
        gwdata = avg_r[l_r];
        d_nxt  = d_r + FlowBits'(avg_r[l_r]) - FlowBits'(grdata);
        if (l_r == 2'd3) begin
          l_nxt  = '0;
          ph_nxt = 1'b0;
          state_nxt = S_FRD;
        end else begin
          l_nxt = l_r + 1'b1;
          state_nxt = S_NWR;
        end
      end
      S_FRD: begin
        faddr = ph_r ? {ctr, k_r[1:0]} : {cur_cell, 2'(3'd3 - k_r)};
        state_nxt = S_FWR;
      end
      S_FWR: begin
        faddr = ph_r ? {ctr, k_r[1:0]} : {cur_cell, 2'(3'd3 - k_r)};
        fwe   = 1'b1;
        fwdata = ph_r ? frdata - d_r : frdata + d_r;
        if (!ph_r) begin
          ph_nxt = 1'b1;
          state_nxt = S_FRD;
        end else begin
          ph_nxt = 1'b0;
          d_nxt  = '0;
          k_nxt  = next_open(k_r + 3'd1, blk_r);
          state_nxt = (next_open(k_r + 3'd1, blk_r) == 3'd4) ? S_CWR : S_NWR;
        end
      end
      S_CWR: begin
        gaddr  = {ctr, l_r};
        gwe    = 1'b1;
        gwdata = cval[GasBits] ? GasMax : cval[GasBits-1:0];
        if (l_r == 2'd3) begin
          l_nxt = '0;
          k_nxt = '0;
          ph_nxt = 1'b0;
          pos_nxt = pos_r + 1'b1;
          // advance to next center; blocked RAM addressed by new ctr next cycle
          state_nxt = (pos_r + 1'b1 == PosEnd) ? S_OUT : S_BLK;
        end else begin
          l_nxt = l_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
      k_r      <= '0;
      l_r      <= '0;
      ph_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
      k_r      <= (state_r == S_IDLE) ? 3'd0 : k_nxt;
      l_r      <= (state_r == S_IDLE) ? '0 : l_nxt;
      ph_r     <= (state_r == S_IDLE) ? 1'b0 : ph_nxt;
    end
    op_r       <= op_nxt;
    cell_r     <= cell_nxt;
    lane_r     <= lane_nxt;
    blk_r      <= blk_nxt;
    sum_r      <= sum_nxt;
    d_r        <= d_nxt;
    rv_r       <= rv_nxt;
    done_bit_r <= done_bit_nxt;
    if (state_r == S_DIV && drsp.done) begin
      avg_r[l_r] <= drsp.quot[GasBits-1:0];
      rem_r[l_r] <= drsp.rem;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_read_value = rv_r;
  assign out_sweep_done = done_bit_r;

  // no new transfer while an item is still working
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input accepted while busy");

  // a result never rises in the cycle after an item is taken
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !$rose(out_valid))
    else $error("result raised right after transfer");

  // sweep position rests at zero between items
  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pos_r == '0))
    else $error("sweep position not cleared");

  // divider only finishes while waiting for it
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_DIV))
    else $error("divider result out of sequence");
endmodule
`default_nettype wire

// File: dv/tb_gas_grid_diffusion_sweep_top.sv
// ----------------------------------------------------------------------------
// tb_gas_grid_diffusion_sweep_top: self-checking bench for the diffusion sweep
// Fills every cell, runs directed and random host traffic and sweeps, and
// checks each result against an in-bench model of the cell stores.
// ----------------------------------------------------------------------------
module tb_gas_grid_diffusion_sweep_top;
  import ggds_pkg::*;

  localparam int Grid      = 16;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               sweep_done;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = OP_WR_GAS;
  logic [7:0]  in_cell_index = '0;
  logic [1:0]  in_lane = '0;
  logic [27:0] in_gas_value = '0;
  logic signed [31:0] in_flow_value = '0;
  logic [3:0]  in_blocked_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] out_read_value;
  logic        out_sweep_done;

  gas_grid_diffusion_sweep_top #(.GRID_SIZE(Grid)) dut (.*);

  always #4 clk = ~clk;

  // model of the stores
  logic [27:0] gas_mdl  [1024];
  logic [31:0] flow_mdl [1024];
  logic [3:0]  blk_mdl  [256];
  cell_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic visit_cell(input logic [7:0] p);
    logic [7:0]  nb[4];
    logic [31:0] sm, avg[4], rem[4], d, v;
    logic [3:0]  blk;
    logic [31:0] open;
    blk = blk_mdl[p];
    nb[0] = p - 8'(Grid);
    nb[1] = p - 8'd1;
    nb[2] = p + 8'd1;
    nb[3] = p + 8'(Grid);
    open = 5 - (blk[0] + blk[1] + blk[2] + blk[3]);
    for (int l = 0; l < 4; l++) begin
      sm = gas_mdl[p*4+l];
      for (int k = 0; k < 4; k++)
        if (!blk[k]) sm += gas_mdl[nb[k]*4+l];
      avg[l] = sm / open;
      rem[l] = sm - avg[l] * open;
    end
    for (int k = 0; k < 4; k++) begin
      if (!blk[k]) begin
        d = 0;
        for (int l = 0; l < 4; l++) begin
          d += avg[l] - {4'd0, gas_mdl[nb[k]*4+l]};
          gas_mdl[nb[k]*4+l] = avg[l][27:0];
        end
        flow_mdl[nb[k]*4+(3-k)] += d;
        flow_mdl[p*4+k] -= d;
      end
    end
    for (int l = 0; l < 4; l++) begin
      v = avg[l] + rem[l];
      if (v > {4'd0, GasMax}) v = {4'd0, GasMax};
      gas_mdl[p*4+l] = v[27:0];
    end
  endtask

  task automatic predict_item(input logic [2:0] op, input logic [7:0] cidx,
                              input logic [1:0] lane, input logic [27:0] gas,
                              input logic [31:0] flow, input logic [3:0] blk);
    cell_result_t r;
    r = '0;
    case (op)
      OP_WR_GAS:  gas_mdl[cidx*4+lane] = gas;
      OP_WR_FLOW: flow_mdl[cidx*4+lane] = flow;
      OP_WR_BLK:  blk_mdl[cidx] = blk;
      OP_SWEEP: begin
        for (int p = Grid; p < Grid*(Grid-1); p++) visit_cell(p[7:0]);
        r.sweep_done = 1'b1;
      end
      OP_RD_GAS:  r.read_value = {4'd0, gas_mdl[cidx*4+lane]};
      OP_RD_FLOW: r.read_value = flow_mdl[cidx*4+lane];
      OP_RD_BLK:  r.read_value = {28'd0, blk_mdl[cidx]};
      default: ;
    endcase
    pending_results.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  logic gaps_on = 1'b1;

  task automatic send_item(input logic [2:0] op, input logic [7:0] cidx,
                           input logic [1:0] lane, input logic [27:0] gas,
                           input logic [31:0] flow, input logic [3:0] blk);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_cell_index   <= cidx;
    in_lane         <= lane;
    in_gas_value    <= gas;
    in_flow_value   <= flow;
    in_blocked_bits <= blk;
    // stall only moves at the rising edge, so the falling-edge value decides
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    predict_item(op, cidx, lane, gas, flow, blk);
    if (gaps_on) begin
      int g;
      g = pick_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  // result checker: a transfer happens at the rising edge after this sample
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_read_value, 32'd0);
      end else begin
        cell_result_t e;
        e = pending_results.pop_front();
        if (out_read_value !== e.read_value)
          report_mismatch("read_value", out_read_value, e.read_value);
        if (out_sweep_done !== e.sweep_done)
          report_mismatch("sweep_done", {31'd0, out_sweep_done}, {31'd0, e.sweep_done});
      end
    end
  end

  // receiver backpressure: phases of none, light and bursty stalling
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      case (stall_mode)
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(5, 60);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [27:0] rand_gas();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GasMax;
      default: return 28'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_flow();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // write every entry once so later reads and sweeps see defined data
  task automatic test_fill();
    for (int c = 0; c < 256; c++) begin
      for (int l = 0; l < 4; l++) begin
        send_item(OP_WR_GAS, c[7:0], l[1:0], rand_gas(), '0, '0);
        send_item(OP_WR_FLOW, c[7:0], l[1:0], '0, rand_flow(), '0);
      end
      send_item(OP_WR_BLK, c[7:0], '0, '0, '0, ($urandom_range(0, 2) == 0) ?
                4'($urandom()) : 4'd0);
    end
  endtask

  task automatic test_directed();
    // saturating center: center 16 and neighbor 17 at max, neighbor 32 one below
    for (int l = 0; l < 4; l++) begin
      send_item(OP_WR_GAS, 8'd16, l[1:0], GasMax, '0, '0);
      send_item(OP_WR_GAS, 8'd32, l[1:0], GasMax - 28'd1, '0, '0);
      send_item(OP_WR_GAS, 8'd17, l[1:0], GasMax, '0, '0);
    end
    send_item(OP_WR_BLK, 8'd16, '0, '0, '0, 4'd0);
    send_item(OP_WR_BLK, 8'd100, '0, '0, '0, 4'hF);
    send_item(OP_WR_BLK, 8'd101, '0, '0, '0, 4'b0101);
    send_item(OP_WR_FLOW, 8'd255, 2'd3, '0, 32'h8000_0000, '0);
    send_item(OP_WR_FLOW, 8'd0, 2'd0, '0, 32'h7FFF_FFFF, '0);
    send_item(OP_RD_FLOW, 8'd255, 2'd3, '0, '0, '0);
    send_item(OP_RD_FLOW, 8'd0, 2'd0, '0, '0, '0);
    send_item(OP_RD_GAS, 8'd16, 2'd3, '0, '0, '0);
    send_item(OP_RD_BLK, 8'd100, '0, '0, '0, '0);
    send_item(3'd7, 8'hFF, 2'd3, GasMax, 32'hFFFF_FFFF, 4'hF);
    send_item(OP_SWEEP, '0, '0, '0, '0, '0);
    send_item(OP_RD_GAS, 8'd16, 2'd0, '0, '0, '0);
    send_item(OP_RD_FLOW, 8'd16, 2'd3, '0, '0, '0);
  endtask

  task automatic test_random();
    logic [2:0] op;
    int r;
    for (int i = 0; i < 240; i++) begin
      gaps_on = (i / 40) % 3 != 1;
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_SWEEP;
      else if (r < 5) op = 3'd7;
      else begin
        op = 3'($urandom_range(0, 5));
        if (op >= OP_SWEEP) op = op + 3'd1;
      end
      send_item(op, 8'($urandom()), 2'($urandom()), rand_gas(), rand_flow(),
                4'($urandom()));
    end
    send_item(OP_SWEEP, '0, '0, '0, '0, '0);
    for (int c = 0; c < 8; c++)
      send_item(OP_RD_GAS, 8'($urandom()), 2'($urandom()), '0, '0, '0);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill();
    test_directed();
    test_random();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/ggds_pkg.sv
sv/ggds_ram.sv
sv/ggds_div.sv
sv/gas_grid_diffusion_sweep_top.sv
dv/tb_gas_grid_diffusion_sweep_top.sv
